[src/tcsp_pkg.sv]
`default_nettype none
package tcsp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES = 31;

  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;
  localparam logic [61:0] MAX31 = 62'd2147483647;

  typedef enum logic [2:0] {
    CFG_TOP_LEVEL    = 3'd0,
    CFG_BOTTOM_LEVEL = 3'd1,
    CFG_TOP_RAD      = 3'd2,
    CFG_BOT_RAD      = 3'd3,
    CFG_ROUND_RADIUS = 3'd4,
    CFG_XZ_SCALE     = 3'd5,
    CFG_SCALE_Y      = 3'd6,
    CFG_EXCLUDE      = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               zero;
  } side_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > MAX32) begin
      return MAX32[31:0];
    end else if (v < MIN32) begin
      return MIN32[31:0];
    end
    return v[31:0];
  endfunction

  function automatic logic [30:0] sat31u(input logic [61:0] v);
    if (v > MAX31) begin
      return MAX31[30:0];
    end
    return v[30:0];
  endfunction

endpackage
`default_nettype wire

[src/tcsp_isqrt.sv]
`default_nettype none
module tcsp_isqrt (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] rad,
  output logic      [31:0] root
);

  logic [63:0] rem_r  [tcsp_pkg::SQRT_STAGES];
  logic [31:0] root_r [tcsp_pkg::SQRT_STAGES];
  logic [63:0] rem_w  [tcsp_pkg::SQRT_STAGES+1];
  logic [31:0] root_w [tcsp_pkg::SQRT_STAGES+1];

  assign rem_w[0]  = rad;
  assign root_w[0] = '0;

  for (genvar k = 0; k < tcsp_pkg::SQRT_STAGES; k++) begin : g_stage
    localparam int B = tcsp_pkg::SQRT_STAGES - 1 - k;
    logic [65:0] trial;
    logic        ge;
    logic [63:0] rem_nxt;
    logic [31:0] root_nxt;

    assign trial    = ({34'd0, root_w[k]} << (B + 1)) | (66'd1 << (2 * B));
    assign ge       = {2'b00, rem_w[k]} >= trial;
    assign rem_nxt  = ge ? rem_w[k] - trial[63:0] : rem_w[k];
    assign root_nxt = ge ? (root_w[k] | (32'd1 << B)) : root_w[k];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
      end
    end

    assign rem_w[k+1]  = rem_r[k];
    assign root_w[k+1] = root_r[k];
  end

  assign root = root_w[tcsp_pkg::SQRT_STAGES];

endmodule
`default_nettype wire

[src/tcsp_div.sv]
`default_nettype none
module tcsp_div (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [61:0] num,
  input  wire logic [31:0] den,
  output logic      [30:0] quo
);

  logic [31:0] rem_r [tcsp_pkg::DIV_STAGES];
  logic [61:0] num_r [tcsp_pkg::DIV_STAGES];
  logic [31:0] den_r [tcsp_pkg::DIV_STAGES];
  logic [30:0] quo_r [tcsp_pkg::DIV_STAGES];
  logic [31:0] rem_w [tcsp_pkg::DIV_STAGES+1];
  logic [61:0] num_w [tcsp_pkg::DIV_STAGES+1];
  logic [31:0] den_w [tcsp_pkg::DIV_STAGES+1];
  logic [30:0] quo_w [tcsp_pkg::DIV_STAGES+1];

  // quotient fits 31 bits, so the top part starts below the divisor
  assign rem_w[0] = {1'b0, num[61:31]};
  assign num_w[0] = num;
  assign den_w[0] = den;
  assign quo_w[0] = '0;

  for (genvar k = 0; k < tcsp_pkg::DIV_STAGES; k++) begin : g_stage
    localparam int B = tcsp_pkg::DIV_STAGES - 1 - k;
    logic [32:0] r2;
    logic [32:0] diff;
    logic        ge;

    assign r2   = {rem_w[k], num_w[k][B]};
    assign diff = r2 - {1'b0, den_w[k]};
    assign ge   = r2 >= {1'b0, den_w[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[31:0] : r2[31:0];
        num_r[k] <= num_w[k];
        den_r[k] <= den_w[k];
        quo_r[k] <= {quo_w[k][29:0], ge};
      end
    end

    assign rem_w[k+1] = rem_r[k];
    assign num_w[k+1] = num_r[k];
    assign den_w[k+1] = den_r[k];
    assign quo_w[k+1] = quo_r[k];
  end

  assign quo = quo_w[tcsp_pkg::DIV_STAGES];

endmodule
`default_nettype wire

[src/tapered_cylinder_support_point.sv]
`default_nettype none
// Support point of a scaled tapered cylinder for one query direction per transfer.
// Fully pipelined: one direction is taken every clock unless the output stalls, and it
// goes through 2 entry stages, 32 square root stages, 1 product stage, 31 divider
// stages and 5 stages for the dot product compare and output. The latency is set by
// the bit-per-stage square root and the four bit-per-stage dividers. A stall on the
// output holds the whole pipeline. Shape registers pass the product, order and
// shrink steps into scaled levels and radii; write them only while the block is idle.
module tapered_cylinder_support_point (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [95:0]  in_tdata,   // dir_x, dir_y, dir_z
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [127:0] out_tdata,  // point_x, point_y, point_z, reported_radius, pad
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata
);

  localparam int FB = tcsp_pkg::FRAC_BITS;
  localparam int SQ = tcsp_pkg::SQRT_STAGES;
  localparam int DV = tcsp_pkg::DIV_STAGES;

  // configuration registers
  logic signed [31:0] top_lvl_r, bot_lvl_r, scale_y_r;
  logic        [30:0] top_rad_r, bot_rad_r, rnd_rad_r, xz_scale_r;
  logic               excl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_lvl_r  <= 32'sd65536;
      bot_lvl_r  <= -32'sd65536;
      top_rad_r  <= 31'd65536;
      bot_rad_r  <= 31'd65536;
      rnd_rad_r  <= '0;
      xz_scale_r <= 31'd65536;
      scale_y_r  <= 32'sd65536;
      excl_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (tcsp_pkg::cfg_idx_t'(cfg_addr))
        tcsp_pkg::CFG_TOP_LEVEL:     top_lvl_r  <= cfg_wdata;
        tcsp_pkg::CFG_BOTTOM_LEVEL:  bot_lvl_r  <= cfg_wdata;
        tcsp_pkg::CFG_TOP_RAD:       top_rad_r  <= cfg_wdata[30:0];
        tcsp_pkg::CFG_BOT_RAD:       bot_rad_r  <= cfg_wdata[30:0];
        tcsp_pkg::CFG_ROUND_RADIUS:  rnd_rad_r  <= cfg_wdata[30:0];
        tcsp_pkg::CFG_XZ_SCALE:      xz_scale_r <= cfg_wdata[30:0];
        tcsp_pkg::CFG_SCALE_Y:       scale_y_r  <= cfg_wdata;
        tcsp_pkg::CFG_EXCLUDE:       excl_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // shape folding, first step: scale products
  logic signed [63:0] ptop_r, pbot_r, ptop_nxt, pbot_nxt;
  logic        [61:0] ptr_r, pbr_r, pc_r, ptr_nxt, pbr_nxt, pc_nxt;
  logic        [31:0] ay;
  logic        [30:0] smin;

  always_comb begin
    ptop_nxt = scale_y_r * top_lvl_r;
    pbot_nxt = scale_y_r * bot_lvl_r;
    ptr_nxt  = xz_scale_r * top_rad_r;
    pbr_nxt  = xz_scale_r * bot_rad_r;
    ay       = scale_y_r[31] ? 32'(-scale_y_r) : 32'(scale_y_r);
    smin     = (ay < {1'b0, xz_scale_r}) ? ay[30:0] : xz_scale_r;
    pc_nxt   = smin * rnd_rad_r;
  end

  // second step: saturate and order the caps
  logic signed [31:0] top2_r, bot2_r, top2_nxt, bot2_nxt, ts, bs;
  logic        [30:0] tr2_r, br2_r, c2_r, tr2_nxt, br2_nxt, trs, brs;

  always_comb begin
    ts  = tcsp_pkg::sat32(ptop_r >>> FB);
    bs  = tcsp_pkg::sat32(pbot_r >>> FB);
    trs = tcsp_pkg::sat31u(ptr_r >> FB);
    brs = tcsp_pkg::sat31u(pbr_r >> FB);
    if (bs > ts) begin
      top2_nxt = bs;
      bot2_nxt = ts;
      tr2_nxt  = brs;
      br2_nxt  = trs;
    end else begin
      top2_nxt = ts;
      bot2_nxt = bs;
      tr2_nxt  = trs;
      br2_nxt  = brs;
    end
  end

  // third step: shrink by the convex radius in exclude mode, else pass through with no radius
  logic signed [31:0] top3_r, bot3_r, top3_nxt, bot3_nxt;
  logic        [30:0] tr3_r, br3_r, c3_r, tr3_nxt, br3_nxt, c3_nxt;

  always_comb begin
    if (excl_r) begin
      top3_nxt = tcsp_pkg::sat32(64'(top2_r) - $signed({33'd0, c2_r}));
      bot3_nxt = tcsp_pkg::sat32(64'(bot2_r) + $signed({33'd0, c2_r}));
      tr3_nxt  = (tr2_r > c2_r) ? tr2_r - c2_r : '0;
      br3_nxt  = (br2_r > c2_r) ? br2_r - c2_r : '0;
      c3_nxt   = c2_r;
    end else begin
      top3_nxt = top2_r;
      bot3_nxt = bot2_r;
      tr3_nxt  = tr2_r;
      br3_nxt  = br2_r;
      c3_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptop_r <= '0;
      pbot_r <= '0;
      ptr_r  <= '0;
      pbr_r  <= '0;
      pc_r   <= '0;
      top2_r <= '0;
      bot2_r <= '0;
      tr2_r  <= '0;
      br2_r  <= '0;
      c2_r   <= '0;
      top3_r <= '0;
      bot3_r <= '0;
      tr3_r  <= '0;
      br3_r  <= '0;
      c3_r   <= '0;
    end else begin
      ptop_r <= ptop_nxt;
      pbot_r <= pbot_nxt;
      ptr_r  <= ptr_nxt;
      pbr_r  <= pbr_nxt;
      pc_r   <= pc_nxt;
      top2_r <= top2_nxt;
      bot2_r <= bot2_nxt;
      tr2_r  <= tr2_nxt;
      br2_r  <= br2_nxt;
      c2_r   <= tcsp_pkg::sat31u(pc_r >> FB);
      top3_r <= top3_nxt;
      bot3_r <= bot3_nxt;
      tr3_r  <= tr3_nxt;
      br3_r  <= br3_nxt;
      c3_r   <= c3_nxt;
    end
  end

  // pipeline
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic               v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, out_v_r;
  logic signed [31:0] x1_r, y1_r, z1_r;
  logic signed [63:0] xx1_r, zz1_r;
  logic        [63:0] sum2_r;
  tcsp_pkg::side_t    sb2_r, sb3_r, sb4_r, sb5_r, sb6_r;
  tcsp_pkg::side_t    sq_sb_r [SQ];
  logic        [SQ-1:0] sq_v_r;
  tcsp_pkg::side_t    dv_sb_r [DV];
  logic        [DV-1:0] dv_v_r;
  logic        [31:0] root, o3_r;
  logic        [61:0] ntx3_r, ntz3_r, nbx3_r, nbz3_r;
  logic        [31:0] ax, az;
  logic        [30:0] qtx, qtz, qbx, qbz;
  logic signed [31:0] tx4_r, tz4_r, bx4_r, bz4_r;
  logic signed [31:0] tx5_r, tz5_r, bx5_r, bz5_r, tx6_r, tz6_r, bx6_r, bz6_r;
  logic signed [31:0] tx7_r, tz7_r, bx7_r, bz7_r;
  logic signed [32:0] dx5_r, dz5_r, dh5_r;
  logic signed [64:0] m1_6_r, m2_6_r, m3_6_r, m3_7_r;
  logic signed [65:0] s12_7_r;
  logic signed [66:0] tot;
  logic               win, zero7_r, ypos7_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic        [30:0] rr_r;

  always_comb begin
    ax = sq_sb_r[SQ-1].x[31] ? 32'(-sq_sb_r[SQ-1].x) : 32'(sq_sb_r[SQ-1].x);
    az = sq_sb_r[SQ-1].z[31] ? 32'(-sq_sb_r[SQ-1].z) : 32'(sq_sb_r[SQ-1].z);
  end

  tcsp_isqrt u_isqrt (.clk(clk), .en(en), .rad(sum2_r), .root(root));

  tcsp_div u_div_tx (.clk(clk), .en(en), .num(ntx3_r), .den(o3_r), .quo(qtx));
  tcsp_div u_div_tz (.clk(clk), .en(en), .num(ntz3_r), .den(o3_r), .quo(qtz));
  tcsp_div u_div_bx (.clk(clk), .en(en), .num(nbx3_r), .den(o3_r), .quo(qbx));
  tcsp_div u_div_bz (.clk(clk), .en(en), .num(nbz3_r), .den(o3_r), .quo(qbz));

  assign tot = 67'(s12_7_r) + 67'(m3_7_r);
  assign win = !tot[66] && (tot != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      sq_v_r  <= '0;
      v3_r    <= 1'b0;
      dv_v_r  <= '0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      v6_r    <= 1'b0;
      v7_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v1_r    <= in_tvalid;
      v2_r    <= v1_r;
      sq_v_r  <= {sq_v_r[SQ-2:0], v2_r};
      v3_r    <= sq_v_r[SQ-1];
      dv_v_r  <= {dv_v_r[DV-2:0], v3_r};
      v4_r    <= dv_v_r[DV-1];
      v5_r    <= v4_r;
      v6_r    <= v5_r;
      v7_r    <= v6_r;
      out_v_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // squares of the horizontal components
      x1_r  <= in_tdata[31:0];
      y1_r  <= in_tdata[63:32];
      z1_r  <= in_tdata[95:64];
      xx1_r <= $signed(in_tdata[31:0]) * $signed(in_tdata[31:0]);
      zz1_r <= $signed(in_tdata[95:64]) * $signed(in_tdata[95:64]);
      sum2_r <= xx1_r + zz1_r;
      sb2_r <= '{x: x1_r, y: y1_r, z: z1_r, zero: (x1_r == '0) && (z1_r == '0)};
      sq_sb_r[0] <= sb2_r;
      for (int i = 1; i < SQ; i++) begin
        sq_sb_r[i] <= sq_sb_r[i-1];
      end
      // rim numerators
      sb3_r  <= sq_sb_r[SQ-1];
      o3_r   <= root;
      ntx3_r <= 62'(tr3_r * ax);
      ntz3_r <= 62'(tr3_r * az);
      nbx3_r <= 62'(br3_r * ax);
      nbz3_r <= 62'(br3_r * az);
      dv_sb_r[0] <= sb3_r;
      for (int i = 1; i < DV; i++) begin
        dv_sb_r[i] <= dv_sb_r[i-1];
      end
      // signed rim points
      sb4_r <= dv_sb_r[DV-1];
      tx4_r <= dv_sb_r[DV-1].x[31] ? -$signed({1'b0, qtx}) : $signed({1'b0, qtx});
      tz4_r <= dv_sb_r[DV-1].z[31] ? -$signed({1'b0, qtz}) : $signed({1'b0, qtz});
      bx4_r <= dv_sb_r[DV-1].x[31] ? -$signed({1'b0, qbx}) : $signed({1'b0, qbx});
      bz4_r <= dv_sb_r[DV-1].z[31] ? -$signed({1'b0, qbz}) : $signed({1'b0, qbz});
      // differences
      sb5_r <= sb4_r;
      dx5_r <= 33'(tx4_r) - 33'(bx4_r);
      dz5_r <= 33'(tz4_r) - 33'(bz4_r);
      dh5_r <= 33'(top3_r) - 33'(bot3_r);
      tx5_r <= tx4_r;
      tz5_r <= tz4_r;
      bx5_r <= bx4_r;
      bz5_r <= bz4_r;
      // dot product terms
      sb6_r  <= sb5_r;
      m1_6_r <= 65'(sb5_r.x) * 65'(dx5_r);
      m2_6_r <= 65'(sb5_r.z) * 65'(dz5_r);
      m3_6_r <= 65'(dh5_r) * 65'(sb5_r.y);
      tx6_r  <= tx5_r;
      tz6_r  <= tz5_r;
      bx6_r  <= bx5_r;
      bz6_r  <= bz5_r;
      // partial sum
      s12_7_r <= 66'(m1_6_r) + 66'(m2_6_r);
      m3_7_r  <= m3_6_r;
      zero7_r <= sb6_r.zero;
      ypos7_r <= !sb6_r.y[31] && (sb6_r.y != '0);
      tx7_r   <= tx6_r;
      tz7_r   <= tz6_r;
      bx7_r   <= bx6_r;
      bz7_r   <= bz6_r;
      // output register
      rr_r <= c3_r;
      if (zero7_r) begin
        px_r <= '0;
        pz_r <= '0;
        py_r <= ypos7_r ? top3_r : bot3_r;
      end else if (win) begin
        px_r <= tx7_r;
        pz_r <= tz7_r;
        py_r <= top3_r;
      end else begin
        px_r <= bx7_r;
        pz_r <= bz7_r;
        py_r <= bot3_r;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, rr_r, pz_r, py_r, px_r};

`ifndef SYNTH
  a_rr_zero_include: assert property (@(posedge clk) disable iff (!rst_n)
    (!excl_r) |=> (c3_r == '0))
    else $error("convex radius reported in include mode");

  a_radius_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (tr3_r <= $past(tr2_r)) && (br3_r <= $past(br2_r)))
    else $error("shrunk radius above scaled radius");

  a_levels_include: assert property (@(posedge clk) disable iff (!rst_n)
    (!excl_r) |=> (top3_r == $past(top2_r)) && (bot3_r == $past(bot2_r)))
    else $error("levels changed in include mode");
`endif

endmodule
`default_nettype wire
